>>> sv/srrw_pkg.sv
// Shared types, constants and helper functions for the selective repeat
// receive window. Used by srrw_core and selective_repeat_receive_window.
// No dependencies.
`default_nettype none

package srrw_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int RUN_W      = $clog2(WINDOW_MAX + 1);
    localparam int OFF_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SIZE_W     = 7;
    localparam int SEQ_W      = 32;
    localparam int MODE_W     = 8;

    typedef logic [WINDOW_MAX-1:0] map_t;
    typedef logic [SEQ_W-1:0]      seq_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 8'd0,
        MODE_END   = 8'd1,
        MODE_DATA  = 8'd2
    } mode_t;

    typedef struct packed {
        logic ack_valid;
        seq_t ack_seq;
        logic write_enable;
        seq_t write_index;
        logic transfer_done;
    } result_t;

    localparam int EFF_W = (RUN_W > SIZE_W) ? RUN_W : SIZE_W;

    function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] ws);
        logic [EFF_W-1:0] ext;
        ext = EFF_W'(ws);
        if (ws == '0) begin
            eff_size = EFF_W'(1);
        end else if (ext > EFF_W'(WINDOW_MAX)) begin
            eff_size = EFF_W'(WINDOW_MAX);
        end else begin
            eff_size = ext;
        end
    endfunction

    function automatic map_t size_mask(input logic [EFF_W-1:0] size);
        map_t ones;
        ones = '1;
        size_mask = ~(ones << size);
    endfunction

endpackage

`default_nettype wire

>>> sv/srrw_core.sv
// Window state and combinational next-state update of the selective repeat receiver.
// Depends on srrw_pkg.
`default_nettype none

module srrw_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         item_accept,
    input  wire logic [srrw_pkg::MODE_W-1:0]  mode,
    input  wire srrw_pkg::seq_t               seq_num,
    input  wire logic                         checksum_ok,
    input  wire logic                         cfg_wen,
    input  wire logic [srrw_pkg::SIZE_W-1:0]  cfg_wdata,
    output srrw_pkg::result_t                 result
);

    logic [srrw_pkg::SIZE_W-1:0] slot_limit_reg, slot_limit_next;
    logic                        session_active_reg, session_active_next;
    srrw_pkg::seq_t              session_number_reg, session_number_next;
    srrw_pkg::seq_t              window_base_reg, window_base_next;
    srrw_pkg::map_t              received_map_reg, received_map_next;

    logic [srrw_pkg::EFF_W-1:0]  size;
    srrw_pkg::map_t              mask;
    srrw_pkg::seq_t              offset;
    srrw_pkg::map_t              map_with_base;
    logic [srrw_pkg::RUN_W-1:0]  run;

    assign size          = srrw_pkg::eff_size(slot_limit_reg);
    assign mask          = srrw_pkg::size_mask(size);
    assign offset        = seq_num - window_base_reg;
    assign map_with_base = (received_map_reg | srrw_pkg::map_t'(1)) & mask;

    always_comb begin
        run = srrw_pkg::RUN_W'(srrw_pkg::WINDOW_MAX);
        for (int i = srrw_pkg::WINDOW_MAX - 1; i >= 0; i--) begin
            if (!map_with_base[i]) begin
                run = srrw_pkg::RUN_W'(i);
            end
        end
    end

    always_comb begin
        result              = '0;
        slot_limit_next     = slot_limit_reg;
        session_active_next = session_active_reg;
        session_number_next = session_number_reg;
        window_base_next    = window_base_reg;
        received_map_next   = received_map_reg;

        if (cfg_wen) begin
            slot_limit_next   = cfg_wdata;
            received_map_next = received_map_reg
                                & srrw_pkg::size_mask(srrw_pkg::eff_size(cfg_wdata));
        end

        if (item_accept && checksum_ok) begin
            unique case (mode)
                srrw_pkg::MODE_START: begin
                    if (!session_active_reg || seq_num == session_number_reg) begin
                        session_active_next = 1'b1;
                        session_number_next = seq_num;
                        result.ack_valid    = 1'b1;
                        result.ack_seq      = seq_num;
                    end
                end
                srrw_pkg::MODE_END: begin
                    if (!session_active_reg || seq_num == session_number_reg) begin
                        session_active_next  = 1'b0;
                        session_number_next  = '0;
                        window_base_next     = '0;
                        received_map_next    = '0;
                        result.ack_valid     = 1'b1;
                        result.ack_seq       = seq_num;
                        result.transfer_done = 1'b1;
                    end
                end
                srrw_pkg::MODE_DATA: begin
                    if (session_active_reg) begin
                        result.ack_valid = 1'b1;
                        result.ack_seq   = window_base_reg;
                        if (seq_num > window_base_reg) begin
                            if (offset < srrw_pkg::SEQ_W'(size)
                                && !received_map_reg[offset[srrw_pkg::OFF_W-1:0]]) begin
                                received_map_next[offset[srrw_pkg::OFF_W-1:0]] = 1'b1;
                                result.write_enable = 1'b1;
                                result.write_index  = seq_num;
                            end
                        end else if (seq_num == window_base_reg) begin
                            if (!received_map_reg[0]) begin
                                result.write_enable = 1'b1;
                                result.write_index  = seq_num;
                            end
                            received_map_next = (map_with_base >> run) & mask;
                            window_base_next  = window_base_reg + srrw_pkg::SEQ_W'(run);
                            result.ack_seq    = window_base_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_limit_reg     <= srrw_pkg::SIZE_W'(8);
            session_active_reg <= 1'b0;
            session_number_reg <= '0;
            window_base_reg    <= '0;
            received_map_reg   <= '0;
        end else begin
            if (cfg_wen) begin
                slot_limit_reg <= slot_limit_next;
            end
            if (cfg_wen || item_accept) begin
                received_map_reg <= received_map_next;
            end
            if (item_accept) begin
                session_active_reg <= session_active_next;
                session_number_reg <= session_number_next;
                window_base_reg    <= window_base_next;
            end
        end
    end

    // Slots at or beyond the effective window never hold a mark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (received_map_reg & ~mask) == '0)
        else $error("received map holds marks outside the window");

    // Without a session the window is empty and at base zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !session_active_reg |-> (window_base_reg == '0 && received_map_reg == '0))
        else $error("window state left over without a session");

    // A write request always comes with an acknowledgement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        result.write_enable |-> result.ack_valid)
        else $error("write requested without acknowledgement");

    // A finished transfer closes the session.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_accept && result.transfer_done) |=> !session_active_reg)
        else $error("session still open after transfer done");

endmodule

`default_nettype wire

>>> sv/selective_repeat_receive_window.sv
// Top level of the selective repeat receive window: stream handshake,
// result register and configuration port. Depends on srrw_pkg and srrw_core.
//
// Each input item is one packet header: s_tdata carries the sequence number,
// s_tuser the packet type and the checksum flag. Every accepted item gives
// exactly one result item on the m_ channel: acknowledgement number and
// chunk write index in m_tdata, and the ack, write and done flags in m_tuser.
// A dropped packet gives a result with all fields zero.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while the receiver does not stall; the window update,
// including the priority encoder over the received map, completes in the
// accepting cycle. When the receiver stalls, the result register holds and
// s_tready falls, so no item is lost; s_tready is high again in the cycle
// the result is taken. The window size register is written through cfg_wen
// and cfg_wdata; the user must do so only while no item is in flight, which
// the block does not enforce. Values of zero count as one, above 64 as 64.
// Synchronous active-low reset clears the session and window; size becomes eight.
`default_nettype none

module selective_repeat_receive_window (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,   // seq_num
    input  wire logic [15:0]                 s_tuser,   // mode, checksum_ok, zero fill
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [63:0]                      m_tdata,   // ack_seq, write_index
    output logic [7:0]                       m_tuser,   // ack_valid, write_enable,
                                                        // transfer_done, zero fill
    input  wire logic                        cfg_wen,
    input  wire logic [7:0]                  cfg_wdata  // slot limit, zero fill
);

    logic              accept;
    srrw_pkg::result_t result;
    srrw_pkg::result_t result_reg;
    logic              m_tvalid_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    srrw_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (accept),
        .mode        (s_tuser[7:0]),
        .seq_num     (s_tdata),
        .checksum_ok (s_tuser[8]),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata[srrw_pkg::SIZE_W-1:0]),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {result_reg.write_index, result_reg.ack_seq};
    assign m_tuser  = {5'b0, result_reg.transfer_done, result_reg.write_enable,
                       result_reg.ack_valid};

endmodule

`default_nettype wire
